### rtl/planar_pose_integrator_unit_assert.svh
// ----------------------------------------------------------------------------
// Planar pose integrator assertion macros
// Clocked, reset-qualified concurrent assertion helpers for the integrator.
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_INTEGRATOR_UNIT_ASSERT_SVH
`define PLANAR_POSE_INTEGRATOR_UNIT_ASSERT_SVH

// Assert a property on an explicit clock and active-low reset.
`define PPI_ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define PPI_ASSERT(label, prop, msg) \
  `PPI_ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// Planar pose integrator package
// Widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

  localparam int POS_W        = 32;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int VEL_W  = 16;
  localparam int STEP_W = 16;

  localparam logic [STEP_W-1:0] TIME_STEP_RESET = STEP_W'(3277);

  // Shared multiplier operand and product widths.
  localparam int MA_W   = 34;
  localparam int MB_W   = 33;
  localparam int PROD_W = MA_W + MB_W;

  // CORDIC datapath widths: x/y in Q2.30 with headroom, z in 2^-32 turn.
  localparam int XY_W = 34;
  localparam int Z_W  = 33;

  localparam logic [29:0] TURN_SCALE   = 30'd683565276;
  localparam logic [31:0] CORDIC_START = 32'h26DD3B6A;

  // Arctangent of 2^-k in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/ppi_if.sv
// ----------------------------------------------------------------------------
// Planar pose integrator stream interfaces
// Valid/ready channels for velocity ticks in and pose results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppi_in_if;
  import ppi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_forward;
  logic signed [VEL_W-1:0] vel_lateral;
  logic signed [VEL_W-1:0] yaw_rate;

  modport source (
    output valid, vel_forward, vel_lateral, yaw_rate,
    input  ready
  );

  modport sink (
    input  valid, vel_forward, vel_lateral, yaw_rate,
    output ready
  );
endinterface

interface ppi_out_if;
  import ppi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   pose_x;
  logic signed [POS_W-1:0]   pose_y;
  logic        [ANGLE_W-1:0] pose_heading;

  modport source (
    output valid, pose_x, pose_y, pose_heading,
    input  ready
  );

  modport sink (
    input  valid, pose_x, pose_y, pose_heading,
    output ready
  );
endinterface

`default_nettype wire

### rtl/planar_pose_integrator_unit.sv
// ----------------------------------------------------------------------------
// Planar pose integrator unit
// Midpoint odometry: rotates body velocity by the half-step heading with an
// iterative CORDIC, integrates position with saturation, wraps the heading.
// ----------------------------------------------------------------------------
// Each accepted tick steps through RATE, TURN, ANGLE, MID, CORDIC, FIX and
// M0 to M6 before the next tick is taken; in_i.ready is high only while the
// unit is idle. The sequence is set by the CORDIC rotation, which runs one
// step per cycle, and by one shared 34x33 multiplier that in turn forms yaw
// rate times dt, the turn scaling, velocity times dt and the four rotation
// products. A finished pose sits in an output register, so the next tick is
// taken while it waits; a tick only stalls in S_M6 while the previous pose
// is not yet transferred. time_step is written through cfg_we_i/cfg_wdata_i;
// write it only while no tick is in flight; the block does not enforce it.
`default_nettype none
`include "planar_pose_integrator_unit_assert.svh"

module planar_pose_integrator_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ppi_pkg::STEP_W-1:0] cfg_wdata_i,
  ppi_in_if.sink                          in_i,
  ppi_out_if.source                       out_o
);
  import ppi_pkg::*;

  localparam int CNT_W  = $clog2(CORDIC_STEPS);
  localparam int SH     = 60 - ANGLE_W;
  localparam int DISP_W = PROD_W - 42;
  localparam int SUM_W  = ((POS_W > DISP_W) ? POS_W : DISP_W) + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RATE   = 4'd1;
  localparam logic [3:0] S_TURN   = 4'd2;
  localparam logic [3:0] S_ANGLE  = 4'd3;
  localparam logic [3:0] S_MID    = 4'd4;
  localparam logic [3:0] S_CORDIC = 4'd5;
  localparam logic [3:0] S_FIX    = 4'd6;
  localparam logic [3:0] S_M0     = 4'd7;
  localparam logic [3:0] S_M1     = 4'd8;
  localparam logic [3:0] S_M2     = 4'd9;
  localparam logic [3:0] S_M3     = 4'd10;
  localparam logic [3:0] S_M4     = 4'd11;
  localparam logic [3:0] S_M5     = 4'd12;
  localparam logic [3:0] S_M6     = 4'd13;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0]  pos,
    input logic signed [DISP_W-1:0] disp
  );
    logic signed [SUM_W-1:0] sum;
    logic                    ovf;
    sum = SUM_W'(pos) + SUM_W'(disp);
    ovf = (sum[SUM_W-1:POS_W-1] != '0) && (sum[SUM_W-1:POS_W-1] != '1);
    if (ovf) begin
      return sum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return sum[POS_W-1:0];
  endfunction

  function automatic logic signed [DISP_W-1:0] round_disp(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [PROD_W-1:0] r;
    r = v + (PROD_W'(1) << 41);
    return r[PROD_W-1:42];
  endfunction

  // Control and state registers
  logic [3:0]                state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [STEP_W-1:0]         time_step_q, time_step_d;
  logic signed [POS_W-1:0]   pos_x_q, pos_x_d;
  logic signed [POS_W-1:0]   pos_y_q, pos_y_d;
  logic [ANGLE_W-1:0]        heading_q, heading_d;
  logic                      out_valid_q, out_valid_d;

  // Datapath registers
  logic signed [VEL_W-1:0]   vx_q, vx_d;
  logic signed [VEL_W-1:0]   vy_q, vy_d;
  logic [VEL_W-1:0]          wz_abs_q, wz_abs_d;
  logic                      wz_neg_q, wz_neg_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [PROD_W-1:0]  acc_q, acc_d;
  logic signed [DISP_W-1:0]  disp_q, disp_d;
  logic signed [MB_W-1:0]    vxdt_q, vxdt_d;
  logic signed [MB_W-1:0]    vydt_q, vydt_d;
  logic [ANGLE_W-1:0]        full_q, full_d;
  logic [ANGLE_W-1:0]        half_q, half_d;
  logic                      flip_q, flip_d;
  logic signed [XY_W-1:0]    cx_q, cx_d;
  logic signed [XY_W-1:0]    cy_q, cy_d;
  logic signed [Z_W-1:0]     z_q, z_d;
  logic signed [POS_W-1:0]   out_x_q, out_x_d;
  logic signed [POS_W-1:0]   out_y_q, out_y_d;
  logic [ANGLE_W-1:0]        out_heading_q, out_heading_d;

  // Shared multiplier
  logic signed [MA_W-1:0]    m_a;
  logic signed [MB_W-1:0]    m_b;
  logic signed [PROD_W-1:0]  m_p;

  logic                      in_xfer;
  logic                      out_xfer;
  logic                      last_go;
  logic [PROD_W-1:0]         full_sum;
  logic [PROD_W-1:0]         half_sum;
  logic [ANGLE_W-1:0]        full_mag;
  logic [ANGLE_W-1:0]        half_mag;
  logic [ANGLE_W-1:0]        mid;
  logic [31:0]               mid_turn;
  logic                      mid_flip;
  logic signed [XY_W-1:0]    dx;
  logic signed [XY_W-1:0]    dy;
  logic signed [Z_W-1:0]     atan_z;

  assign in_i.ready         = (state_q == S_IDLE);
  assign in_xfer            = in_i.valid && in_i.ready;
  assign out_xfer           = out_valid_q && out_o.ready;
  assign last_go            = (state_q == S_M6) && (!out_valid_q || out_o.ready);

  assign out_o.valid        = out_valid_q;
  assign out_o.pose_x       = out_x_q;
  assign out_o.pose_y       = out_y_q;
  assign out_o.pose_heading = out_heading_q;

  // Heading increments, rounded on the magnitude
  assign full_sum = prod_q + (PROD_W'(1) << (SH - 1));
  assign half_sum = prod_q + (PROD_W'(1) << SH);
  assign full_mag = full_sum[SH +: ANGLE_W];
  assign half_mag = half_sum[(SH + 1) +: ANGLE_W];

  // Midpoint angle folded into the right half-plane
  assign mid      = heading_q + half_q;
  assign mid_turn = {mid, {(32 - ANGLE_W){1'b0}}};
  assign mid_flip = mid_turn[31] ^ mid_turn[30];

  assign dx     = cy_q >>> cnt_q;
  assign dy     = cx_q >>> cnt_q;
  assign atan_z = Z_W'(atan_turn(5'(cnt_q)));

  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (state_q)
      S_RATE: begin
        m_a = MA_W'(wz_abs_q);
        m_b = MB_W'(time_step_q);
      end
      S_TURN: begin
        m_a = MA_W'(TURN_SCALE);
        m_b = prod_q[MB_W-1:0];
      end
      S_CORDIC: begin
        m_a = (cnt_q == CNT_W'(0)) ? MA_W'(vx_q) : MA_W'(vy_q);
        m_b = MB_W'(time_step_q);
      end
      S_M0: begin
        m_a = cx_q;
        m_b = vxdt_q;
      end
      S_M1: begin
        m_a = cy_q;
        m_b = vydt_q;
      end
      S_M2: begin
        m_a = cy_q;
        m_b = vxdt_q;
      end
      S_M3: begin
        m_a = cx_q;
        m_b = vydt_q;
      end
      default: begin
        m_a = '0;
        m_b = '0;
      end
    endcase
  end

  assign m_p = m_a * m_b;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    time_step_d   = cfg_we_i ? cfg_wdata_i : time_step_q;
    pos_x_d       = pos_x_q;
    pos_y_d       = pos_y_q;
    heading_d     = heading_q;
    out_valid_d   = out_xfer ? 1'b0 : out_valid_q;
    vx_d          = vx_q;
    vy_d          = vy_q;
    wz_abs_d      = wz_abs_q;
    wz_neg_d      = wz_neg_q;
    prod_d        = prod_q;
    acc_d         = acc_q;
    disp_d        = disp_q;
    vxdt_d        = vxdt_q;
    vydt_d        = vydt_q;
    full_d        = full_q;
    half_d        = half_q;
    flip_d        = flip_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    z_d           = z_q;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    out_heading_d = out_heading_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          vx_d     = in_i.vel_forward;
          vy_d     = in_i.vel_lateral;
          wz_neg_d = in_i.yaw_rate[VEL_W-1];
          wz_abs_d = in_i.yaw_rate[VEL_W-1] ? VEL_W'(-in_i.yaw_rate) : in_i.yaw_rate;
          state_d  = S_RATE;
        end
      end
      S_RATE: begin
        prod_d  = m_p;
        state_d = S_TURN;
      end
      S_TURN: begin
        prod_d  = m_p;
        state_d = S_ANGLE;
      end
      S_ANGLE: begin
        full_d  = wz_neg_q ? ANGLE_W'(-full_mag) : full_mag;
        half_d  = wz_neg_q ? ANGLE_W'(-half_mag) : half_mag;
        state_d = S_MID;
      end
      S_MID: begin
        flip_d  = mid_flip;
        z_d     = Z_W'(signed'({mid_turn[31] ^ mid_flip, mid_turn[30:0]}));
        cx_d    = XY_W'(CORDIC_START);
        cy_d    = '0;
        cnt_d   = '0;
        state_d = S_CORDIC;
      end
      S_CORDIC: begin
        if (cnt_q == CNT_W'(0)) begin
          vxdt_d = m_p[MB_W-1:0];
        end
        if (cnt_q == CNT_W'(1)) begin
          vydt_d = m_p[MB_W-1:0];
        end
        if (!z_q[Z_W-1]) begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          z_d  = z_q - atan_z;
        end else begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          z_d  = z_q + atan_z;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (flip_q) begin
          cx_d = -cx_q;
          cy_d = -cy_q;
        end
        state_d = S_M0;
      end
      S_M0: begin
        prod_d  = m_p;
        state_d = S_M1;
      end
      S_M1: begin
        acc_d   = prod_q;
        prod_d  = m_p;
        state_d = S_M2;
      end
      S_M2: begin
        acc_d   = acc_q - prod_q;
        prod_d  = m_p;
        state_d = S_M3;
      end
      S_M3: begin
        disp_d  = round_disp(acc_q);
        acc_d   = prod_q;
        prod_d  = m_p;
        state_d = S_M4;
      end
      S_M4: begin
        pos_x_d = sat_add(pos_x_q, disp_q);
        acc_d   = acc_q + prod_q;
        state_d = S_M5;
      end
      S_M5: begin
        disp_d  = round_disp(acc_q);
        state_d = S_M6;
      end
      S_M6: begin
        if (last_go) begin
          pos_y_d       = sat_add(pos_y_q, disp_q);
          heading_d     = heading_q + full_q;
          out_x_d       = pos_x_q;
          out_y_d       = pos_y_d;
          out_heading_d = heading_d;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      time_step_q <= TIME_STEP_RESET;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      time_step_q <= time_step_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q          <= vx_d;
    vy_q          <= vy_d;
    wz_abs_q      <= wz_abs_d;
    wz_neg_q      <= wz_neg_d;
    prod_q        <= prod_d;
    acc_q         <= acc_d;
    disp_q        <= disp_d;
    vxdt_q        <= vxdt_d;
    vydt_q        <= vydt_d;
    full_q        <= full_d;
    half_q        <= half_d;
    flip_q        <= flip_d;
    cx_q          <= cx_d;
    cy_q          <= cy_d;
    z_q           <= z_d;
    out_x_q       <= out_x_d;
    out_y_q       <= out_y_d;
    out_heading_q <= out_heading_d;
  end

  `PPI_ASSERT(a_accept_starts, in_xfer |=> state_q == S_RATE, "tick transfer did not start work")
  `PPI_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(state_q) == S_M6, "pose appeared outside final step")
  `PPI_ASSERT(a_stall_holds, (state_q == S_M6) && out_valid_q && !out_o.ready |=> state_q == S_M6, "final step advanced over a pending pose")
  `PPI_ASSERT(a_cordic_full, state_q == S_FIX |-> ($past(state_q) == S_CORDIC) && ($past(cnt_q) == CNT_LAST), "rotation ended early")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Planar pose integrator testbench
// Sends velocity ticks through the valid/ready input in bursts while the
// receiver stalls on patterns of its own. Each pose is predicted with a
// bit-exact midpoint integrator (half-step heading, iterative CORDIC, saturated
// position, wrapped heading), and every transferred pose is checked field by
// field. Covers the reset, zero and full time steps, back-pressure, random
// ticks and a long straight run at full speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ppi_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic        [ANGLE_W-1:0] heading;
  } pose_t;

  typedef enum int unsigned {FIELD_FULL, FIELD_SMALL, FIELD_EXTREME, FIELD_MIXED} field_kind_e;
  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_mode_e;

  localparam logic [STEP_W-1:0]       DEFAULT_STEP  = STEP_W'(3277);
  localparam logic [STEP_W-1:0]       STEP_MAX      = '1;
  localparam logic signed [VEL_W-1:0] VEL_MAX       = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN       = {1'b1, {(VEL_W-1){1'b0}}};
  localparam longint unsigned         TURN_UNITS    = 64'd683565276;
  localparam longint                  ROTATOR_START = 64'h26DD3B6A;
  localparam longint                  ROUND_BIT     = longint'(1) << 41;
  localparam longint                  POS_HI        = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint                  POS_LO        = -POS_HI - 1;
  localparam int                      HOLD_CYCLES   = 300;
  localparam int                      STALL_LIMIT   = 2000;
  localparam int                      SETTLE_CYCLES = 64;
  localparam int                      PHASE_TICKS   = 130;
  localparam int                      RUN_TICKS     = 300;

  // arctangent of 2^-k in 2^-32 turn units, entry 0 in the low word
  localparam logic [24*32-1:0] ARCTAN_TABLE = {
    32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C, 32'h00000518, 32'h00000A30,
    32'h0000145F, 32'h000028BE, 32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53, 32'h00517C55, 32'h00A2F61E,
    32'h0145D7E1, 32'h028B0D43, 32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [STEP_W-1:0] cfg_wdata_i;

  ppi_in_if  in_if ();
  ppi_out_if out_if ();

  pose_t             expected_poses[$];
  pose_t             tracked_pose = '0;
  logic [STEP_W-1:0] step_dt      = DEFAULT_STEP;
  int unsigned       mismatches   = 0;
  int unsigned       burst_left   = 0;
  bit                hold_req     = 1'b0;

  planar_pose_integrator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic pose_t integrate_tick(input pose_t cur, input logic [STEP_W-1:0] dt,
                                           input logic signed [VEL_W-1:0] vf,
                                           input logic signed [VEL_W-1:0] vl,
                                           input logic signed [VEL_W-1:0] wz);
    pose_t              nxt;
    longint unsigned    abs_w, dt_u, mag, full_turn, half_turn;
    longint             w, dt_s, vx_l, vy_l, rx, ry, rz, dx, dy, arc, c, s, wx, wy, px, py;
    logic [31:0]        ang;
    logic [ANGLE_W-1:0] mid;
    logic               flip;
    int                 sh;
    sh   = 60 - ANGLE_W;
    w    = wz;
    vx_l = vf;
    vy_l = vl;
    dt_s = dt;
    dt_u = dt;
    abs_w = (w < 0) ? -w : w;
    mag = abs_w * dt_u * TURN_UNITS;
    full_turn = (mag + (64'd1 << (sh - 1))) >> sh;
    half_turn = (mag + (64'd1 << sh)) >> (sh + 1);
    if (w < 0) begin
      full_turn = -full_turn;
      half_turn = -half_turn;
    end
    mid  = cur.heading + half_turn[ANGLE_W-1:0];
    ang  = {mid, {(32-ANGLE_W){1'b0}}};
    // fold the left half-plane onto the right one
    flip = ang[31] ^ ang[30];
    if (flip) begin
      ang[31] = ~ang[31];
    end
    rz = $signed(ang);
    rx = ROTATOR_START;
    ry = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx  = ry >>> i;
      dy  = rx >>> i;
      arc = ARCTAN_TABLE[32*i +: 32];
      if (rz >= 0) begin
        rx = rx - dx;
        ry = ry + dy;
        rz = rz - arc;
      end else begin
        rx = rx + dx;
        ry = ry - dy;
        rz = rz + arc;
      end
    end
    c  = flip ? -rx : rx;
    s  = flip ? -ry : ry;
    wx = c * vx_l - s * vy_l;
    wy = s * vx_l + c * vy_l;
    px = {{(64-POS_W){cur.x[POS_W-1]}}, cur.x};
    py = {{(64-POS_W){cur.y[POS_W-1]}}, cur.y};
    px = px + ((wx * dt_s + ROUND_BIT) >>> 42);
    py = py + ((wy * dt_s + ROUND_BIT) >>> 42);
    if (px > POS_HI) begin
      px = POS_HI;
    end else if (px < POS_LO) begin
      px = POS_LO;
    end
    if (py > POS_HI) begin
      py = POS_HI;
    end else if (py < POS_LO) begin
      py = POS_LO;
    end
    nxt.x       = px[POS_W-1:0];
    nxt.y       = py[POS_W-1:0];
    nxt.heading = cur.heading + full_turn[ANGLE_W-1:0];
    return nxt;
  endfunction

  function automatic logic signed [VEL_W-1:0] pick_field(input field_kind_e kind);
    field_kind_e k;
    k = (kind == FIELD_MIXED) ? field_kind_e'($urandom_range(0, 2)) : kind;
    case (k)
      FIELD_SMALL: begin
        return VEL_W'(int'($urandom_range(0, 511)) - 256);
      end
      FIELD_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return VEL_MIN;
          1:       return VEL_W'(-1);
          2:       return VEL_W'(0);
          3:       return VEL_W'(1);
          default: return VEL_MAX;
        endcase
      end
      default: begin
        return VEL_W'($urandom);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : pose_checker
    pose_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: pose expected none actual x=%0d y=%0d heading=%0d", $time,
                 out_if.pose_x, out_if.pose_y, out_if.pose_heading);
        mismatches++;
      end else begin
        want = expected_poses.pop_front();
        if (out_if.pose_x !== want.x) begin
          $display("%0t: pose_x expected %0d actual %0d", $time, want.x, out_if.pose_x);
          mismatches++;
        end
        if (out_if.pose_y !== want.y) begin
          $display("%0t: pose_y expected %0d actual %0d", $time, want.y, out_if.pose_y);
          mismatches++;
        end
        if (out_if.pose_heading !== want.heading) begin
          $display("%0t: pose_heading expected %0d actual %0d", $time, want.heading,
                   out_if.pose_heading);
          mismatches++;
        end
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      tracked_pose = integrate_tick(tracked_pose, step_dt, in_if.vel_forward,
                                    in_if.vel_lateral, in_if.yaw_rate);
      expected_poses.push_back(tracked_pose);
    end
  end

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    logic [15:0] pattern;
    mode      = RX_ALWAYS;
    mode_left = 0;
    pattern   = '1;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 160);
        pattern   = 16'($urandom) | 16'h0001;
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: begin
          out_if.ready = 1'b1;
        end
        RX_COIN: begin
          out_if.ready = 1'($urandom_range(0, 1));
        end
        default: begin
          out_if.ready = pattern[0];
          pattern      = {pattern[0], pattern[15:1]};
        end
      endcase
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_tick(input logic signed [VEL_W-1:0] vf,
                           input logic signed [VEL_W-1:0] vl,
                           input logic signed [VEL_W-1:0] wz);
    int unsigned gap;
    in_if.vel_forward = vf;
    in_if.vel_lateral = vl;
    in_if.yaw_rate    = wz;
    in_if.valid       = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(4, 29);
        default: gap = $urandom_range(30, 60);
      endcase
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 23);
    end
  endtask

  task automatic send_random_tick();
    int unsigned shape;
    field_kind_e kind;
    shape = $urandom_range(0, 9);
    if (shape < 6) begin
      kind = FIELD_FULL;
    end else if (shape < 8) begin
      kind = FIELD_SMALL;
    end else if (shape == 8) begin
      kind = FIELD_EXTREME;
    end else begin
      kind = FIELD_MIXED;
    end
    send_tick(pick_field(kind), pick_field(kind), pick_field(kind));
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (expected_poses.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_time_step(input logic [STEP_W-1:0] value);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    step_dt  = value;
  endtask

  task automatic test_default_step();
    send_tick(0, 0, 0);
    send_tick(VEL_MAX, 0, 0);
    send_tick(VEL_MIN, 0, 0);
    send_tick(0, VEL_MAX, 0);
    send_tick(0, VEL_MIN, 0);
    send_tick(0, 0, VEL_MAX);
    send_tick(0, 0, VEL_MIN);
    send_tick(VEL_MAX, VEL_MIN, VEL_MAX);
    send_tick(VEL_MIN, VEL_MAX, VEL_MIN);
    send_tick(1, -1, 1);
    send_tick(-1, 1, -1);
    wait_drained();
  endtask

  task automatic test_zero_step();
    write_time_step('0);
    send_tick(VEL_MAX, VEL_MAX, VEL_MAX);
    repeat (4) send_random_tick();
    wait_drained();
  endtask

  task automatic test_full_step();
    write_time_step(STEP_MAX);
    send_tick(0, 0, VEL_MAX);
    send_tick(0, 0, VEL_MIN);
    send_tick(0, 0, -1);
    send_tick(VEL_MAX, VEL_MIN, 12345);
    send_tick(VEL_MIN, VEL_MIN, VEL_MAX);
    send_tick(VEL_MAX, VEL_MAX, VEL_MIN);
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_time_step(DEFAULT_STEP);
    // hold the receiver off while ticks keep coming
    hold_req = 1'b1;
    repeat (8) send_random_tick();
    wait_drained();
    repeat (8) send_random_tick();
    wait_drained();
  endtask

  task automatic test_random_ticks();
    logic [STEP_W-1:0] phase_step;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       phase_step = STEP_W'(1);
        1:       phase_step = STEP_MAX;
        2:       phase_step = DEFAULT_STEP;
        3:       phase_step = STEP_W'($urandom_range(2, 2047));
        4:       phase_step = STEP_W'($urandom_range(30000, 65534));
        default: phase_step = STEP_W'($urandom);
      endcase
      write_time_step(phase_step);
      repeat (PHASE_TICKS) send_random_tick();
      wait_drained();
    end
  endtask

  task automatic test_straight_run();
    int  heading_s;
    int  yaw_fix;
    real per_count;
    write_time_step(STEP_MAX);
    // turn the heading back to about zero so the push runs along +x and -y
    per_count = 65535.0 * $itor(TURN_UNITS) / (2.0 ** (60 - ANGLE_W));
    heading_s = $signed(tracked_pose.heading);
    yaw_fix   = -$rtoi($itor(heading_s) / per_count);
    send_tick(0, 0, VEL_W'(yaw_fix));
    wait_drained();
    repeat (RUN_TICKS) send_tick(VEL_MAX, VEL_MIN, 0);
    repeat (8) send_random_tick();
    wait_drained();
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.vel_forward = '0;
    in_if.vel_lateral = '0;
    in_if.yaw_rate    = '0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    rst_ni            = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_step();
    test_zero_step();
    test_full_step();
    test_backpressure();
    test_random_ticks();
    test_straight_run();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
